FILE: rtl/core/pidc_pkg.sv
package pidc_pkg;

    // Field and arithmetic widths
    localparam int DATA_WIDTH   = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int GAIN_W       = 16;
    localparam int TARGET_W     = 16;
    localparam int LIMIT_W      = 15;
    localparam int RESCALE_BITS = 8;

    localparam int ERR_W  = ((DATA_WIDTH > TARGET_W) ? DATA_WIDTH : TARGET_W) + 1;
    localparam int DIFF_W = ERR_W + 1;

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_WIDTH;
    localparam int PROD_D_W = GAIN_W + DIFF_W;
    localparam int PROD_MAX_W =
        (PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W;
    localparam int ACC_W = PROD_MAX_W + 2;
    localparam int VAL_W = ACC_W - RESCALE_BITS;

    // Reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(3840);  // 15.0
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(25600);  // 100.0

    // Config port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_PROP    = 3'd0,
        REG_GAIN_INTEG   = 3'd1,
        REG_GAIN_DERIV   = 3'd2,
        REG_TARGET_VALUE = 3'd3,
        REG_DRIVE_LIMIT  = 3'd4
    } pidc_reg_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [SUM_WIDTH-1:0] sum;
        logic signed [DIFF_W-1:0]    diff;
    } pidc_work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pidc_qstat_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0]       limit;
    } pidc_gains_t;

endpackage

FILE: rtl/core/pid_controller_with_clamp.sv
// PID controller with symmetric output clamp, signed Q8.8 throughout.
//
// Sample channel: measured with sample_valid / sample_stall. One beat per
// cycle is taken while sample_stall stays low; a beat is accepted when
// sample_valid is high and sample_stall is low.
// Result channel: drive and clamped with result_valid / result_stall.
// Path: an accepted sample is written to a queue entry, then moves to the
// product register, then to the output register that drives result_valid.
// Throughput: one beat per cycle, sustained; the front never waits on the
// back unless the two-entry queue fills.
// Stall: when result_stall holds, the output register keeps its beat, the
// product stage and the queue fill, and sample_stall rises once the queue
// is full. No beat is dropped or repeated.
// Reset (rst_n low, async): integrator and previous error go to zero,
// gains to 0, target to 15.0, drive limit to 100.0; all valids clear.
// Config: APB, always ready, registers at 4*index; write only while the
// block holds no beat in flight.
module pid_controller_with_clamp
    import pidc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [DATA_WIDTH-1:0] measured,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] drive,
    output logic                         clamped,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    // Config registers
    logic signed [GAIN_W-1:0]   gain_prop_reg, gain_prop_next;
    logic signed [GAIN_W-1:0]   gain_integ_reg, gain_integ_next;
    logic signed [GAIN_W-1:0]   gain_deriv_reg, gain_deriv_next;
    logic signed [TARGET_W-1:0] target_value_reg, target_value_next;
    logic [LIMIT_W-1:0]         drive_limit_reg, drive_limit_next;

    logic        cfg_wr;
    pidc_reg_t   reg_idx;

    // Front/back plumbing
    pidc_qstat_t qstat;
    pidc_work_t  work;
    pidc_work_t  head;
    logic        push;
    logic        pop;
    pidc_gains_t gains;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = pidc_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        gain_prop_next    = gain_prop_reg;
        gain_integ_next   = gain_integ_reg;
        gain_deriv_next   = gain_deriv_reg;
        target_value_next = target_value_reg;
        drive_limit_next  = drive_limit_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_GAIN_PROP:    gain_prop_next    = pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG:   gain_integ_next   = pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:   gain_deriv_next   = pwdata[GAIN_W-1:0];
                REG_TARGET_VALUE: target_value_next = pwdata[TARGET_W-1:0];
                REG_DRIVE_LIMIT:  drive_limit_next  = pwdata[LIMIT_W-1:0];
                default:          ; // unmapped address, write dropped
            endcase
        end
    end

    // Readback: raw register bits, zero-extended
    always_comb
    begin
        case (reg_idx)
            REG_GAIN_PROP:    prdata = APB_DATA_W'(unsigned'(gain_prop_reg));
            REG_GAIN_INTEG:   prdata = APB_DATA_W'(unsigned'(gain_integ_reg));
            REG_GAIN_DERIV:   prdata = APB_DATA_W'(unsigned'(gain_deriv_reg));
            REG_TARGET_VALUE: prdata = APB_DATA_W'(unsigned'(target_value_reg));
            REG_DRIVE_LIMIT:  prdata = APB_DATA_W'(drive_limit_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg    <= '0;
            gain_integ_reg   <= '0;
            gain_deriv_reg   <= '0;
            target_value_reg <= TARGET_RESET;
            drive_limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            gain_prop_reg    <= gain_prop_next;
            gain_integ_reg   <= gain_integ_next;
            gain_deriv_reg   <= gain_deriv_next;
            target_value_reg <= target_value_next;
            drive_limit_reg  <= drive_limit_next;
        end
    end

    assign gains.kp    = gain_prop_reg;
    assign gains.ki    = gain_integ_reg;
    assign gains.kd    = gain_deriv_reg;
    assign gains.limit = drive_limit_reg;

    // Front: error, integrator, derivative difference
    pidc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .measured     (measured),
        .sample_stall (sample_stall),
        .target       (target_value_reg),
        .qstat        (qstat),
        .push         (push),
        .work         (work)
    );

    // Decoupling queue
    pidc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (work),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Back: gain products, rescale, clamp
    pidc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .head         (head),
        .pop          (pop),
        .gains        (gains),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive        (drive),
        .clamped      (clamped)
    );

`ifndef SYNTHESIS
    logic signed [LIMIT_W:0] lim_chk;
    assign lim_chk = {1'b0, drive_limit_reg};

    // drive never leaves the clamp window
    a_drive_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(drive) <= lim_chk && $signed(drive) >= -lim_chk))
        else $error("drive outside clamp window");

    // a clamped beat sits exactly on one of the bounds
    a_clamp_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clamped) |->
            ($signed(drive) == lim_chk || $signed(drive) == -lim_chk))
        else $error("clamped beat not on a bound");

    // front only pushes into a queue with room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue overflow");
`endif

endmodule

FILE: rtl/core/pidc_front.sv
// Error, saturating integrator and derivative difference; one beat a cycle while the queue has room.
module pidc_front
    import pidc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    input  logic signed [DATA_WIDTH-1:0] measured,
    output logic                         sample_stall,
    input  logic signed [TARGET_W-1:0]   target,
    input  pidc_qstat_t                  qstat,
    output logic                         push,
    output pidc_work_t                   work
);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [ERR_W-1:0]     last_error_reg, last_error_next;
    logic signed [SUM_WIDTH-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [DIFF_W-1:0]    diff;

    assign sample_stall = qstat.full;
    assign push         = sample_valid && !qstat.full;

    always_comb
    begin
        err      = ERR_W'(measured) - ERR_W'(target);
        sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        diff = DIFF_W'(err) - DIFF_W'(last_error_reg);

        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        if (push)
        begin
            last_error_next = err;
            error_sum_next  = sum_sat;
        end

        work.err  = err;
        work.sum  = sum_sat;
        work.diff = diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

endmodule

FILE: rtl/core/pidc_queue.sv
// Small FIFO of work beats between front and back.
module pidc_queue
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pidc_work_t  push_data,
    input  logic        pop,
    output pidc_work_t  head,
    output pidc_qstat_t qstat
);

    pidc_work_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/pidc_back.sv
// Product stage, then sum/rescale/clamp into the output register.
module pidc_back
    import pidc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidc_qstat_t                  qstat,
    input  pidc_work_t                   head,
    output logic                         pop,
    input  pidc_gains_t                  gains,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] drive,
    output logic                         clamped
);

    logic                         prod_valid_reg, prod_valid_next;
    logic signed [PROD_P_W-1:0]   prod_p_reg;
    logic signed [PROD_I_W-1:0]   prod_i_reg;
    logic signed [PROD_D_W-1:0]   prod_d_reg;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         clamped_reg;

    logic                         out_load;
    logic                         prod_load;
    logic signed [ACC_W-1:0]      acc;
    logic signed [VAL_W-1:0]      val;
    logic signed [VAL_W-1:0]      lim_pos;
    logic signed [VAL_W-1:0]      lim_neg;
    logic signed [VAL_W-1:0]      val_clip;
    logic                         clip;

    assign out_load  = !out_valid_reg || !result_stall;
    assign prod_load = !prod_valid_reg || out_load;
    assign pop       = prod_load && !qstat.empty;

    always_comb
    begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        // arithmetic shift: floor toward minus infinity
        val     = VAL_W'(acc >>> RESCALE_BITS);
        lim_pos = VAL_W'(gains.limit);
        lim_neg = -lim_pos;
        if (val > lim_pos)
        begin
            val_clip = lim_pos;
            clip     = 1'b1;
        end
        else if (val < lim_neg)
        begin
            val_clip = lim_neg;
            clip     = 1'b1;
        end
        else
        begin
            val_clip = val;
            clip     = 1'b0;
        end

        prod_valid_next = prod_load ? pop : prod_valid_reg;
        out_valid_next  = out_load ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_p_reg <= gains.kp * head.err;
            prod_i_reg <= gains.ki * head.sum;
            prod_d_reg <= gains.kd * head.diff;
        end
        if (out_load && prod_valid_reg)
        begin
            drive_reg   <= DATA_WIDTH'(val_clip);
            clamped_reg <= clip;
        end
    end

    assign result_valid = out_valid_reg;
    assign drive        = drive_reg;
    assign clamped      = clamped_reg;

endmodule

FILE: dv/pidc_drive_check.sv
`timescale 1ns / 1ps

// Watches the sample, result and APB channels, tracks the register file and
// the integrator, and checks every result beat against its sample.
module pidc_drive_check
    import pidc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         sample_valid,
    input  logic                         sample_stall,
    input  logic signed [DATA_WIDTH-1:0] measured,

    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic signed [DATA_WIDTH-1:0] drive,
    input  logic                         clamped,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,

    output int                           mismatch_count,
    output int                           outstanding,
    output int                           results_checked,
    output int                           clamp_hits,
    output int                           sat_hits
);

    localparam longint SUM_HI      = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_LO      = -SUM_HI - 1;
    localparam int     MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         clamped;
    } drive_beat_t;

    drive_beat_t pending_drives[$];

    // register copy
    logic signed [GAIN_W-1:0]    kp, ki, kd;
    logic signed [TARGET_W-1:0]  target;
    logic [LIMIT_W-1:0]          limit;

    // controller state
    logic signed [ERR_W-1:0]     prev_err;
    logic signed [SUM_WIDTH-1:0] err_sum;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compute_drive(input logic signed [DATA_WIDTH-1:0] meas,
                                 output drive_beat_t beat);
        longint err, diff, sum_next, acc, val, lim;
        logic   clip;
        err      = longint'(meas) - longint'(target);
        sum_next = longint'(err_sum) + err;
        if (sum_next > SUM_HI || sum_next < SUM_LO)
            sat_hits++;
        if (sum_next > SUM_HI)
            sum_next = SUM_HI;
        else if (sum_next < SUM_LO)
            sum_next = SUM_LO;
        err_sum  = sum_next[SUM_WIDTH-1:0];
        diff     = err - longint'(prev_err);
        prev_err = err[ERR_W-1:0];
        // Q.16 products, then floor back to Q8.8
        acc  = longint'(kp) * err + longint'(ki) * longint'(err_sum)
             + longint'(kd) * diff;
        val  = acc >>> RESCALE_BITS;
        lim  = longint'(limit);
        clip = 1'b0;
        if (val > lim) begin
            val  = lim;
            clip = 1'b1;
        end
        else if (val < -lim) begin
            val  = -lim;
            clip = 1'b1;
        end
        beat.value   = val[DATA_WIDTH-1:0];
        beat.clamped = clip;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp       = '0;
            ki       = '0;
            kd       = '0;
            target   = TARGET_RESET;
            limit    = LIMIT_RESET;
            prev_err = '0;
            err_sum  = '0;
            pending_drives.delete();
            outstanding = 0;
        end
        else
        begin
            drive_beat_t beat;
            drive_beat_t want;
            logic [REG_IDX_W-1:0] idx;
            if (result_valid && !result_stall)
            begin
                if (pending_drives.size() == 0)
                    report_mismatch($sformatf("result beat %0d/%0b with no sample pending",
                                              drive, clamped));
                else
                begin
                    want = pending_drives.pop_front();
                    if (drive !== want.value)
                        report_mismatch($sformatf("beat %0d drive got %0d want %0d",
                                                  results_checked, drive, want.value));
                    if (clamped !== want.clamped)
                        report_mismatch($sformatf("beat %0d clamped got %0b want %0b",
                                                  results_checked, clamped, want.clamped));
                    if (want.clamped)
                        clamp_hits++;
                    results_checked++;
                end
            end
            if (sample_valid && !sample_stall)
            begin
                compute_drive(measured, beat);
                pending_drives.push_back(beat);
            end
            if (psel && penable && pwrite && pready)
            begin
                idx = paddr[APB_ADDR_W-1:2];
                case (idx)
                    REG_GAIN_PROP:    kp     = pwdata[GAIN_W-1:0];
                    REG_GAIN_INTEG:   ki     = pwdata[GAIN_W-1:0];
                    REG_GAIN_DERIV:   kd     = pwdata[GAIN_W-1:0];
                    REG_TARGET_VALUE: target = pwdata[TARGET_W-1:0];
                    REG_DRIVE_LIMIT:  limit  = pwdata[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            outstanding = pending_drives.size();
        end
    end

endmodule

FILE: dv/tb_pid_controller_with_clamp.sv
`timescale 1ns / 1ps

// Top level: clock, reset, stimulus and verdict. All result checking lives in
// pidc_drive_check, which sits beside the block and only listens.
module tb_pid_controller_with_clamp;
    import pidc_pkg::*;

    localparam int CLK_HALF      = 10;      // 20 ns period
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_MAX     = 8;       // longest idle burst, either side
    localparam int HOLD_CYCLES   = 60;      // long output hold, fills the queue
    localparam int DRAIN_CYCLES  = 8;       // slack once no result is outstanding
    localparam int IDLE_LIMIT    = 4000;    // watchdog: cycles with no beat moving
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_BEATS   = 110;
    localparam int WINDUP_CHUNKS = 4;       // first two wind up, rest wind down
    localparam int WINDUP_UP     = 2;
    localparam int WINDUP_BEATS  = 70;

    // First register index past the map; writes there must be dropped.
    localparam int REG_SPARE_FIRST = int'(REG_DRIVE_LIMIT) + 1;
    localparam int REG_SPARE_LAST  = (1 << REG_IDX_W) - 1;

    logic                         clk;
    logic                         rst_n;
    logic                         sample_valid;
    logic                         sample_stall;
    logic signed [DATA_WIDTH-1:0] measured;
    logic                         result_valid;
    logic                         result_stall;
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         clamped;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;

    int mismatch_count, outstanding, results_checked, clamp_hits, sat_hits;
    int samples_sent;
    int settings_used;
    int idle_cycles;

    // Knobs shared between the sender and the receiver process.
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;

    pid_controller_with_clamp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .measured     (measured),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive        (drive),
        .clamped      (clamped),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pidc_drive_check drive_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .measured        (measured),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .drive           (drive),
        .clamped         (clamped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .clamp_hits      (clamp_hits),
        .sat_hits        (sat_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat on either channel, or APB traffic, counts as
    // progress. A hang anywhere ends the run as a failure.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Receiver: result_stall in random bursts no longer than STALL_MAX while
    // rx_idle_en is set. A hold request from the sender side makes it
    // stall for HOLD_CYCLES straight, so the product stage and the
    // two-entry queue fill and sample_stall has to rise.
    // One NBA to result_stall per edge.
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        int hold_left;
        burst        = 0;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, STALL_MAX) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side helpers. Everything is driven right after a rising edge.
    // ------------------------------------------------------------------

    // Offer one sample beat and hold it until taken. valid stays up into
    // the next call unless a random gap is inserted here.
    task automatic put_sample(input logic [DATA_WIDTH-1:0] word);
        sample_valid <= 1'b1;
        measured     <= word;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        samples_sent++;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
        end
    endtask

    // Stop offering, wait until every sample has its result, then give the
    // pipe its DRAIN_CYCLES slack before anything touches the registers.
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never touch psel twice in one step.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program the whole loop. Bits above each register's width carry junk
    // and must be dropped by the block.
    task automatic program_loop(input logic [GAIN_W-1:0] kp,
                                input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd,
                                input logic [TARGET_W-1:0] tgt,
                                input logic [LIMIT_W-1:0] lim);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_GAIN_PROP,    {junk[APB_DATA_W-1:GAIN_W], kp});
        junk = $urandom;
        write_reg(REG_GAIN_INTEG,   {junk[APB_DATA_W-1:GAIN_W], ki});
        junk = $urandom;
        write_reg(REG_GAIN_DERIV,   {junk[APB_DATA_W-1:GAIN_W], kd});
        junk = $urandom;
        write_reg(REG_TARGET_VALUE, {junk[APB_DATA_W-1:TARGET_W], tgt});
        junk = $urandom;
        write_reg(REG_DRIVE_LIMIT,  {junk[APB_DATA_W-1:LIMIT_W], lim});
        settings_used++;
    endtask

    // 16-bit Q8.8 word, leaning on the extremes and on small magnitudes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       pick_word = 16'h7FFF;
            1:       pick_word = 16'h8000;
            2:       pick_word = 16'h0000;
            3:       pick_word = 16'($urandom_range(0, 16'h0600)) - 16'h0300;
            default: pick_word = 16'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       pick_limit = '0;
            1:       pick_limit = '1;
            2:       pick_limit = LIMIT_W'($urandom_range(16'h0040, 16'h2000));
            default: pick_limit = LIMIT_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0]        kp, ki, kd, tgt, meas;
        logic [LIMIT_W-1:0] lim;
        bit                 pressure;
        bit                 wind_up;
        int                 hold_at;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        measured     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_req     = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: all gains zero, so drive is 0 whatever comes in.
        put_sample(16'h0F00);
        put_sample(16'h7FFF);
        settle();

        // Writes past the register map go nowhere.
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            write_reg(REG_IDX_W'(i), $urandom);

        // Kp = 1.0, target 0: drive follows the sample. Covers the input
        // extremes and both bit patterns; -128.0 exceeds the widest limit.
        program_loop(16'h0100, 16'h0000, 16'h0000, 16'h0000, '1);
        put_sample(16'h7FFF);
        put_sample(16'h8000);
        put_sample(16'h0000);
        put_sample(16'hFFFF);
        put_sample(16'h5555);
        put_sample(16'hAAAA);
        settle();

        // Limit 1.0: exactly on the bound passes, one LSB past it clamps.
        write_reg(REG_DRIVE_LIMIT, APB_DATA_W'(16'h0100));
        put_sample(16'h0100);
        put_sample(16'h0101);
        put_sample(16'hFF00);
        put_sample(16'hFEFF);
        settle();

        // Zero limit: drive pinned to 0, flag on for any nonzero value.
        write_reg(REG_DRIVE_LIMIT, '0);
        put_sample(16'h0000);
        put_sample(16'h0001);
        put_sample(16'hFFFF);
        settle();

        // Extreme gains and targets, swinging the error between zero and each of its
        // extremes so the derivative sees steps of the largest magnitude from zero.
        program_loop(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, '1);
        put_sample(16'h8000);
        put_sample(16'h7FFF);
        put_sample(16'h8000);
        put_sample(16'h7FFF);
        settle();
        program_loop(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, LIMIT_RESET);
        put_sample(16'h7FFF);
        put_sample(16'h7FFF);
        put_sample(16'h7FFF);
        put_sample(16'h8000);
        settle();

        // Random phases: new register set per phase, idling toggled in
        // stretches. Two phases run the sender flat out and ask for one
        // long output hold to back the block up.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            pressure = (p == 2 || p == 7);
            kp  = pick_word();
            ki  = ($urandom_range(0, 2) == 0) ? 16'h0000 : pick_word();
            kd  = pick_word();
            tgt = pick_word();
            lim = pick_limit();
            program_loop(kp, ki, kd, tgt, lim);
            hold_at = $urandom_range(10, PHASE_BEATS - 40);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (i % 32 == 0)
                begin
                    tx_idle_en = !pressure && ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end
                if (pressure && i == hold_at)
                    hold_req = 1'b1;
                if ($urandom_range(0, 2) == 0)
                    meas = tgt + 16'($urandom_range(0, 64)) - 16'd32;
                else
                    meas = pick_word();
                put_sample(meas);
            end
            settle();
        end

        // Windup: no idling from here on. Samples near one rail with the
        // target on the other push the integrator hard one way, then
        // swing it back the other way.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int c = 0; c < WINDUP_CHUNKS; c++)
        begin
            wind_up = (c < WINDUP_UP);
            tgt = wind_up ? 16'h8000 : 16'h7FFF;
            program_loop(pick_word(), pick_word(), pick_word(), tgt, pick_limit());
            for (int i = 0; i < WINDUP_BEATS; i++)
            begin
                if (wind_up)
                    meas = 16'($urandom_range(16'h7000, 16'h7FFF));
                else
                    meas = 16'h8000 + 16'($urandom_range(0, 16'h0FFF));
                put_sample(meas);
            end
            settle();
        end

        $display("run covered %0d samples over %0d register sets; %0d results checked, %0d clamped",
                 samples_sent, settings_used, results_checked, clamp_hits);
        $display("integrator hit its rail on %0d samples; long output holds backed up the input twice",
                 sat_hits);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
